// ===== hdl/rnp_pkg.sv =====
package rnp_pkg;

  localparam int LengthWidthDef = 16;
  localparam int QueueDepth = 4;
  localparam int MinPayload = 64;
  localparam int AudioSsrcOffset = 1000;
  localparam int AuPayloadType = 102;
  localparam int RtpHeadBytes = 12;

  localparam logic [3:0] RegCodec = 4'h0;
  localparam logic [3:0] RegSsrc = 4'h4;
  localparam logic [3:0] RegMaxPay = 4'h8;

  localparam logic [7:0] RtpVersionByte = 8'h80;
  localparam logic [4:0] FuaType = 5'h1c;
  localparam logic [5:0] HevcFuType = 6'h31;
  localparam logic [7:0] AuHeadLen = 8'h10;

  localparam logic [1:0] PhWaitHi = 2'd3;
  localparam logic [1:0] PhWaitLo = 2'd2;
  localparam logic [1:0] PhFirst = 2'd1;
  localparam logic [1:0] PhLater = 2'd0;

  // one emission job: everything the back end needs to stream a run of bytes
  typedef struct packed {
    logic        hdr;
    logic        marker;
    logic [6:0]  pt;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [31:0] ssrc;
    logic [2:0]  ext_len;
    logic [31:0] ext;
    logic [7:0]  data;
    logic        pend;
  } rnp_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rnp_qstat_t;

  function automatic logic whole_marker(input logic [7:0] b, input logic hevc);
    logic [5:0] t;
    logic [4:0] u;
    t = b[6:1];
    u = b[4:0];
    if (hevc) begin
      whole_marker = !(t == 6'd32 || t == 6'd33 || t == 6'd34 || t == 6'd39 || t == 6'd40);
    end else begin
      whole_marker = !(u == 5'd6 || u == 5'd7 || u == 5'd8);
    end
  endfunction

endpackage

// ===== hdl/rnp_if.sv =====
interface rnp_in_if #(parameter int LENGTH_WIDTH = 16);
  logic                    valid;
  logic                    ready;
  logic                    mode;
  logic [7:0]              data_byte;
  logic                    unit_first;
  logic [LENGTH_WIDTH-1:0] unit_length;
  logic [31:0]             media_time;
  logic [6:0]              payload_kind;

  modport source (output valid, mode, data_byte, unit_first, unit_length, media_time,
                  payload_kind, input ready);
  modport sink (input valid, mode, data_byte, unit_first, unit_length, media_time,
                payload_kind, output ready);
endinterface

interface rnp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       packet_end;
  logic       run_end;

  modport source (output valid, out_byte, packet_end, run_end, input ready);
  modport sink (input valid, out_byte, packet_end, run_end, output ready);
endinterface

// ===== hdl/rnp_front.sv =====
module rnp_front #(
  parameter int LENGTH_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    acc,
  input  logic                    mode,
  input  logic [7:0]              data_byte,
  input  logic                    unit_first,
  input  logic [LENGTH_WIDTH-1:0] unit_length,
  input  logic [31:0]             media_time,
  input  logic [6:0]              payload_kind,
  input  logic                    codec_sel,
  input  logic [31:0]             ssrc,
  input  logic [11:0]             max_pay,
  output logic                    push,
  output rnp_pkg::rnp_job_t       job
);
  import rnp_pkg::*;

  logic [15:0]             vseq_r, vseq_nxt, aseq_r, aseq_nxt;
  logic [LENGTH_WIDTH-1:0] bl_r, bl_nxt;
  logic [11:0]             cl_r, cl_nxt;
  logic [15:0]             nh_r, nh_nxt;
  logic [31:0]             ut_r, ut_nxt;
  logic [11:0]             fl_r, fl_nxt;

  logic [11:0]             mp;
  logic [LENGTH_WIDTH-1:0] len;
  logic [23:0]             blx;
  logic                    f_bit, aud, frg, hev, lst, sb, eb;
  logic [1:0]              ph;
  logic [7:0]              h0;

  assign mp = (max_pay < 12'(MinPayload)) ? 12'(MinPayload) : max_pay;

  always_comb begin
    vseq_nxt = vseq_r;
    aseq_nxt = aseq_r;
    bl_nxt = bl_r;
    cl_nxt = cl_r;
    nh_nxt = nh_r;
    ut_nxt = ut_r;
    fl_nxt = fl_r;
    push = 1'b0;
    job = '0;
    len = (unit_length == '0) ? LENGTH_WIDTH'(1) : unit_length;
    f_bit = len > LENGTH_WIDTH'(mp);
    blx = '0;
    aud = 1'b0;
    frg = 1'b0;
    hev = 1'b0;
    ph = PhLater;
    lst = 1'b0;
    sb = 1'b0;
    eb = 1'b0;
    h0 = '0;
    if (acc && (unit_first || bl_r != '0)) begin
      if (unit_first) begin
        fl_nxt = {((f_bit && !mode) ? (codec_sel ? PhWaitHi : PhWaitLo) : PhLater),
                  codec_sel, f_bit, mode, payload_kind};
        bl_nxt = len;
        cl_nxt = '0;
        nh_nxt = '0;
        ut_nxt = media_time;
      end
      aud = fl_nxt[7];
      frg = fl_nxt[8];
      hev = fl_nxt[9];
      ph = fl_nxt[11:10];
      if (ph == PhWaitHi) begin
        nh_nxt = {data_byte, 8'h00};
        fl_nxt[11:10] = PhWaitLo;
        bl_nxt = bl_nxt - LENGTH_WIDTH'(1);
      end else if (ph == PhWaitLo) begin
        nh_nxt = hev ? {nh_nxt[15:8], data_byte} : {8'h00, data_byte};
        fl_nxt[11:10] = PhFirst;
        bl_nxt = bl_nxt - LENGTH_WIDTH'(1);
      end else begin
        push = 1'b1;
        blx = 24'(bl_nxt);
        job.pt = fl_nxt[6:0];
        job.ts = ut_nxt;
        job.seq = aud ? aseq_r : vseq_r;
        job.ssrc = aud ? ssrc + 32'(AudioSsrcOffset) : ssrc;
        job.data = data_byte;
        if (cl_nxt == '0) begin
          job.hdr = 1'b1;
          if (aud) aseq_nxt = aseq_r + 16'd1;
          else vseq_nxt = vseq_r + 16'd1;
          if (frg) begin
            lst = bl_nxt <= LENGTH_WIDTH'(mp);
            cl_nxt = lst ? bl_nxt[11:0] : mp;
            job.marker = lst;
            if (!aud) begin
              sb = (ph == PhFirst);
              eb = lst;
              h0 = nh_nxt[15:8];
              if (hev) begin
                job.ext_len = 3'd3;
                job.ext = {h0[7], HevcFuType, h0[0], nh_nxt[7:0], sb, eb, h0[6:1], 8'h00};
              end else begin
                job.ext_len = 3'd2;
                job.ext = {nh_nxt[7:5], FuaType, sb, eb, 1'b0, nh_nxt[4:0], 16'h0000};
              end
              fl_nxt[11:10] = PhLater;
            end
          end else begin
            cl_nxt = (bl_nxt[11:0] == '0) ? 12'd1 : bl_nxt[11:0];
            job.marker = aud ? 1'b1 : whole_marker(data_byte, hev);
            if (aud && fl_nxt[6:0] == 7'(AuPayloadType)) begin
              job.ext_len = 3'd4;
              job.ext = {8'h00, AuHeadLen, blx[12:5], blx[4:0], 3'b000};
            end
          end
        end
        job.pend = (cl_nxt == 12'd1);
        cl_nxt = cl_nxt - 12'd1;
        bl_nxt = bl_nxt - LENGTH_WIDTH'(1);
        if (bl_nxt == '0) cl_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vseq_r <= '0;
      aseq_r <= '0;
      bl_r <= '0;
      cl_r <= '0;
      nh_r <= '0;
      ut_r <= '0;
      fl_r <= '0;
    end else begin
      vseq_r <= vseq_nxt;
      aseq_r <= aseq_nxt;
      bl_r <= bl_nxt;
      cl_r <= cl_nxt;
      nh_r <= nh_nxt;
      ut_r <= ut_nxt;
      fl_r <= fl_nxt;
    end
  end
endmodule

// ===== hdl/rnp_queue.sv =====
module rnp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rnp_pkg::rnp_job_t  push_job,
  input  logic               pop,
  output rnp_pkg::rnp_job_t  head_job,
  output rnp_pkg::rnp_qstat_t stat
);
  import rnp_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  rnp_job_t          mem_r [QueueDepth];
  logic [PtrW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]     cnt_r, cnt_nxt;

  assign stat.full = (cnt_r == (PtrW+1)'(QueueDepth));
  assign stat.empty = (cnt_r == '0);
  assign head_job = mem_r[rp_r];

  always_comb begin
    wp_nxt = wp_r + PtrW'(push);
    rp_nxt = rp_r + PtrW'(pop);
    cnt_nxt = cnt_r + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// ===== hdl/rnp_back.sv =====
module rnp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  rnp_pkg::rnp_job_t job,
  input  logic              out_ready,
  output logic              pop,
  output logic [7:0]        out_byte,
  output logic              packet_end,
  output logic              run_end
);
  import rnp_pkg::*;

  logic [4:0] idx_r, idx_nxt;
  logic [4:0] hdr_n;
  logic [4:0] eidx;
  logic       last;

  assign hdr_n = job.hdr ? 5'(RtpHeadBytes) : 5'd0;
  assign eidx = idx_r - hdr_n;
  assign last = (idx_r == hdr_n + 5'(job.ext_len));
  assign pop = head_valid && out_ready && last;
  assign packet_end = last && job.pend;
  assign run_end = last;

  always_comb begin
    out_byte = job.data;
    if (job.hdr && idx_r < 5'(RtpHeadBytes)) begin
      case (idx_r[3:0])
        4'd0:    out_byte = RtpVersionByte;
        4'd1:    out_byte = {job.marker, job.pt};
        4'd2:    out_byte = job.seq[15:8];
        4'd3:    out_byte = job.seq[7:0];
        4'd4:    out_byte = job.ts[31:24];
        4'd5:    out_byte = job.ts[23:16];
        4'd6:    out_byte = job.ts[15:8];
        4'd7:    out_byte = job.ts[7:0];
        4'd8:    out_byte = job.ssrc[31:24];
        4'd9:    out_byte = job.ssrc[23:16];
        4'd10:   out_byte = job.ssrc[15:8];
        default: out_byte = job.ssrc[7:0];
      endcase
    end else if (eidx < 5'(job.ext_len)) begin
      case (eidx[1:0])
        2'd0:    out_byte = job.ext[31:24];
        2'd1:    out_byte = job.ext[23:16];
        2'd2:    out_byte = job.ext[15:8];
        default: out_byte = job.ext[7:0];
      endcase
    end
  end

  always_comb begin
    idx_nxt = idx_r;
    if (head_valid && out_ready) idx_nxt = last ? 5'd0 : idx_r + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) idx_r <= '0;
    else idx_r <= idx_nxt;
  end
endmodule

// ===== hdl/rnp_nal_packetizer_top.sv =====
// rtp_nal_packetizer_top: each accepted request's job is registered into the job queue before its first output byte
// payload bytes sustain one request per cycle while the job queue is not full; a request that opens a packet
// produces 13 to 17 output bytes, drained one per cycle while out_ready is high, by the back-end byte counter
// a four-entry job queue lets the front accept while the back still drains
// rst_n is synchronous active low: clears sequence numbers, unit state, queue,
// and loads register defaults (codec 0, ssrc 1, max payload 1400)
module rtp_nal_packetizer_top #(
  parameter int LENGTH_WIDTH = rnp_pkg::LengthWidthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  rnp_in_if.sink      in_s,
  rnp_out_if.source   out_s,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rnp_pkg::*;

  // configuration registers
  logic        codec_r;
  logic [31:0] ssrc_r;
  logic [11:0] maxp_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codec_r <= 1'b0;
      ssrc_r <= 32'd1;
      maxp_r <= 12'd1400;
    end else if (wr_en) begin
      case (paddr)
        RegCodec:  codec_r <= pwdata[0];
        RegSsrc:   ssrc_r <= pwdata;
        RegMaxPay: maxp_r <= pwdata[11:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr)
      RegCodec:  prdata = {31'd0, codec_r};
      RegSsrc:   prdata = ssrc_r;
      RegMaxPay: prdata = {20'd0, maxp_r};
      default:   prdata = '0;
    endcase
  end

  // front: classify each request and build its emission job; NAL header bytes of a fragmented video unit build none
  rnp_job_t   fjob, hjob;
  rnp_qstat_t qst;
  logic       in_acc, push, pop;

  assign in_s.ready = !qst.full;
  assign in_acc = in_s.valid && in_s.ready;

  rnp_front #(.LENGTH_WIDTH(LENGTH_WIDTH)) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .acc          (in_acc),
    .mode         (in_s.mode),
    .data_byte    (in_s.data_byte),
    .unit_first   (in_s.unit_first),
    .unit_length  (in_s.unit_length),
    .media_time   (in_s.media_time),
    .payload_kind (in_s.payload_kind),
    .codec_sel    (codec_r),
    .ssrc         (ssrc_r),
    .max_pay      (maxp_r),
    .push         (push),
    .job          (fjob)
  );

  // job queue between front and back
  rnp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (fjob),
    .pop      (pop),
    .head_job (hjob),
    .stat     (qst)
  );

  // back: stream header, extension and payload byte of the head job
  assign out_s.valid = !qst.empty;

  rnp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!qst.empty),
    .job        (hjob),
    .out_ready  (out_s.ready),
    .pop        (pop),
    .out_byte   (out_s.out_byte),
    .packet_end (out_s.packet_end),
    .run_end    (out_s.run_end)
  );

  // never write into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && qst.full)) else $error("job pushed into full queue");

  // never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && qst.empty)) else $error("job popped from empty queue");

  // packet end only on the last byte of a run
  a_pend_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_s.valid && out_s.packet_end) |-> out_s.run_end)
    else $error("packet end before run end");
endmodule
